// File: src/ptd_pkg.sv
// Shared types and constants for the trial-division prime factoriser.
// Used by ptd_ctrl, ptd_datapath and the top level; no other dependencies.
`timescale 1ns / 1ps

package ptd_pkg;

	// default width of the value and factor fields
	localparam int DEF_VALUE_WIDTH = 31;

	// the only even prime, and the first odd candidate
	localparam int FACTOR_TWO = 2;
	localparam int FIRST_ODD  = 3;

	// controller states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_TWOS  = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_TEST  = 6'b100000
	} state_t;

	// where an emitted factor comes from
	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_TWO  = 2'd1,
		SRC_REM  = 2'd2,
		SRC_CAND = 2'd3
	} src_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic shift2;
		logic div_start;
		logic div_step;
		logic next_cand;
		logic take_quot;
		logic emit;
		src_t src;
		logic last;
		logic invalid;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rem_zero;
		logic rem_one;
		logic rem_odd;
		logic half_one;
		logic sq_gt_rem;
		logic div_last;
		logic div_exact;
		logic quot_one;
		logic emit_ok;
	} sts_t;

endpackage

// File: src/ptd_ctrl.sv
// Controller state machine for the trial-division prime factoriser.
// Depends on ptd_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ptd_ctrl
	import ptd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t st_q, st_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// next state and commands
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.src  = SRC_ZERO;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d     = ST_START;
				end
			end
			ST_START: begin
				// zero and one each give a single empty result
				if (sts.rem_zero || sts.rem_one) begin
					if (sts.emit_ok) begin
						cmd.emit    = 1'b1;
						cmd.src     = SRC_ZERO;
						cmd.last    = 1'b1;
						cmd.invalid = sts.rem_zero;
						st_d        = ST_IDLE;
					end
				end else begin
					st_d = ST_TWOS;
				end
			end
			ST_TWOS: begin
				// strip factors of two one per cycle while the output register can take them
				if (!sts.rem_odd) begin
					if (sts.emit_ok) begin
						cmd.emit   = 1'b1;
						cmd.src    = SRC_TWO;
						cmd.last   = sts.half_one;
						cmd.shift2 = 1'b1;
						if (sts.half_one) begin
							st_d = ST_IDLE;
						end
					end
				end else begin
					st_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// candidate squared above remainder: remainder is prime
				if (sts.sq_gt_rem) begin
					if (sts.emit_ok) begin
						cmd.emit = 1'b1;
						cmd.src  = SRC_REM;
						cmd.last = 1'b1;
						st_d     = ST_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					st_d          = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					st_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.div_exact) begin
					if (sts.emit_ok) begin
						cmd.emit      = 1'b1;
						cmd.src       = SRC_CAND;
						cmd.last      = sts.quot_one;
						cmd.take_quot = 1'b1;
						st_d          = sts.quot_one ? ST_IDLE : ST_CHECK;
					end
				end else begin
					cmd.next_cand = 1'b1;
					st_d          = ST_CHECK;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// a factor is emitted only from the states that produce one
	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (st_q == ST_START || st_q == ST_TWOS ||
			st_q == ST_CHECK || st_q == ST_TEST))
		else $error("emit outside a producing state");

	// every division runs to its end before being tested, test may wait on the output
	a_div_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_TEST) |-> ($past(st_q) == ST_TEST || $past(sts.div_last)))
		else $error("test entered before division finished");

	// a new request is taken only once the previous run has ended, and a taken request always starts a run
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (st_q == ST_START))
		else $error("load did not start a run");

endmodule

// File: src/ptd_datapath.sv
// Datapath of the trial-division prime factoriser: remainder, candidate,
// candidate square, restoring divider and output register. Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_datapath
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic [VALUE_WIDTH-1:0] factor,
	output logic                   last,
	output logic                   invalid,
	output logic                   out_valid,
	input  logic                   out_ready
);

	// candidate never exceeds about the square root of the value, plus two
	localparam int CW    = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int SQ_W  = 2 * CW;
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [CW-1:0]          part_q;
	logic [CW-1:0]          cand_q;
	logic [SQ_W-1:0]        sq_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] factor_q;
	logic                   last_q;
	logic                   invalid_q;
	logic                   out_valid_q;

	logic [CW:0]            trial;
	logic                   fits;
	logic [VALUE_WIDTH-1:0] emit_val;

	// one restoring division step: shift in the next dividend bit
	assign trial = {part_q, quot_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, cand_q};

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= value;
			cand_q <= CW'(FIRST_ODD);
			sq_q   <= SQ_W'(FIRST_ODD * FIRST_ODD);
		end else begin
			if (cmd.shift2) begin
				rem_q <= rem_q >> 1;
			end
			if (cmd.take_quot) begin
				rem_q <= quot_q;
			end
			// (c + 2)^2 = c^2 + 4c + 4
			if (cmd.next_cand) begin
				cand_q <= cand_q + CW'(2);
				sq_q   <= sq_q + SQ_W'({cand_q, 2'b00}) + SQ_W'(4);
			end
		end
		if (cmd.div_start) begin
			quot_q <= rem_q;
			part_q <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[VALUE_WIDTH-2:0], fits};
			part_q <= fits ? CW'(trial - {1'b0, cand_q}) : CW'(trial);
		end
	end

	// division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// factor selection
	always_comb begin
		case (cmd.src)
			SRC_ZERO: emit_val = '0;
			SRC_TWO:  emit_val = VALUE_WIDTH'(FACTOR_TWO);
			SRC_REM:  emit_val = rem_q;
			SRC_CAND: emit_val = VALUE_WIDTH'(cand_q);
			default:  emit_val = '0;
		endcase
	end

	// output register, refilled in the cycle its request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			factor_q  <= emit_val;
			last_q    <= cmd.last;
			invalid_q <= cmd.invalid;
		end
	end

	// status
	always_comb begin
		sts.rem_zero  = rem_q == '0;
		sts.rem_one   = rem_q == VALUE_WIDTH'(1);
		sts.rem_odd   = rem_q[0];
		sts.half_one  = (rem_q >> 1) == VALUE_WIDTH'(1);
		sts.sq_gt_rem = sq_q > SQ_W'(rem_q);
		sts.div_last  = cnt_q == CNT_W'(VALUE_WIDTH - 1);
		sts.div_exact = part_q == '0;
		sts.quot_one  = quot_q == VALUE_WIDTH'(1);
		sts.emit_ok   = !out_valid_q || out_ready;
	end

	assign factor    = factor_q;
	assign last      = last_q;
	assign invalid   = invalid_q;
	assign out_valid = out_valid_q;

	// never overwrite a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// a candidate is reported only when it divides exactly
	a_exact_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.src == SRC_CAND) |-> (part_q == '0))
		else $error("candidate emitted with nonzero remainder");

	// a prime remainder is always odd and above one
	a_rem_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.src == SRC_REM) |-> (rem_q[0] && rem_q != VALUE_WIDTH'(1)))
		else $error("bad final remainder");

	// an invalid result carries no factor and ends its run
	a_invalid_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && invalid_q) |-> (factor_q == '0 && last_q))
		else $error("invalid result with a factor");

endmodule

// File: src/prime_factorizer_trial_division_top.sv
// A request is taken in idle; factors of two are stripped one at a time, then each odd
// candidate gets a bound check, a division by the one-bit-per-cycle restoring divider
// and one test; one request at a time.
// Results leave through an output register; reset (arst_n) returns to idle.
`timescale 1ns / 1ps

module prime_factorizer_trial_division_top
	import ptd_pkg::*;
#(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] factor,
	output logic                   last,
	output logic                   invalid
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and result register
	ptd_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.factor    (factor),
		.last      (last),
		.invalid   (invalid),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

// File: tb/tb.sv
// Self-checking bench for prime_factorizer_trial_division_top: random and directed requests,
// a trial-division predictor in a small scoreboard class, random stalls on both sides.
// Depends on ptd_pkg and the top level in src/.
`timescale 1ns / 1ps

module tb;
	import ptd_pkg::*;

	localparam int W = DEF_VALUE_WIDTH;
	localparam int RANDOM_REQUESTS = 76;

	typedef struct packed {
		logic [W-1:0] factor;
		logic         last;
		logic         invalid;
	} factor_rec_t;

	// expected factor runs, filled on each accepted request
	class factor_scoreboard;
		factor_rec_t pending_factors[$];
		int          mismatch_count;

		function new();
			mismatch_count = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		function void push_factor(input longint unsigned f, input logic is_invalid);
			factor_rec_t rec;
			rec.factor  = f[W-1:0];
			rec.last    = 1'b0;
			rec.invalid = is_invalid;
			pending_factors.push_back(rec);
		endfunction

		// trial division: twos first, odd candidates up to the square root, then the remainder
		function void note_request(input logic [W-1:0] v);
			longint unsigned rest;
			longint unsigned cand;
			rest = 64'(v);
			if (rest == 0) begin
				push_factor(0, 1'b1);
			end else if (rest == 1) begin
				push_factor(0, 1'b0);
			end else begin
				while (rest[0] == 1'b0) begin
					push_factor(FACTOR_TWO, 1'b0);
					rest = rest >> 1;
				end
				for (cand = FIRST_ODD; cand <= rest / cand; cand += 2) begin
					while (rest % cand == 0) begin
						push_factor(cand, 1'b0);
						rest = rest / cand;
					end
				end
				if (rest > FACTOR_TWO)
					push_factor(rest, 1'b0);
			end
			pending_factors[pending_factors.size()-1].last = 1'b1;
		endfunction

		task check_result(input logic [W-1:0] f, input logic l, input logic inv);
			factor_rec_t exp_rec;
			if (pending_factors.size() == 0) begin
				report_mismatch($sformatf("unexpected result factor=%0d last=%0b invalid=%0b",
					f, l, inv));
			end else begin
				exp_rec = pending_factors.pop_front();
				if (f !== exp_rec.factor)
					report_mismatch($sformatf("factor %0d, expected %0d", f, exp_rec.factor));
				if (l !== exp_rec.last)
					report_mismatch($sformatf("last %0b, expected %0b (factor %0d)",
						l, exp_rec.last, exp_rec.factor));
				if (inv !== exp_rec.invalid)
					report_mismatch($sformatf("invalid %0b, expected %0b (factor %0d)",
						inv, exp_rec.invalid, exp_rec.factor));
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_ready;
	logic [W-1:0] value;
	logic         out_valid;
	logic         out_ready;
	logic [W-1:0] factor;
	logic         last;
	logic         invalid;

	factor_scoreboard sb = new();
	bit               steady = 1'b0;
	int               results_seen = 0;
	int               small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43,
		47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	prime_factorizer_trial_division_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor   (factor),
		.last     (last),
		.invalid  (invalid)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit, well above the slowest legal run
	initial begin
		#10_000_000;
		$display("prime_factorizer_trial_division_top test failed");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random value: smooth products, shifted 16-bit values, or tiny values
	function automatic logic [W-1:0] random_value();
		int unsigned     kind;
		longint unsigned v;
		longint unsigned p;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			v = 1;
			repeat ($urandom_range(1, 14)) begin
				p = 64'(small_primes[$urandom_range(0, 24)]);
				if (v * p < (64'd1 << W))
					v = v * p;
			end
		end else if (kind < 85) begin
			v = longint'($urandom_range(2, 65535)) << $urandom_range(0, 15);
		end else begin
			v = 64'($urandom_range(0, 40));
		end
		return v[W-1:0];
	endfunction

	// offer one request and hold it until taken
	task automatic send_value(input logic [W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_request(v);
	endtask

	// result side: check each accepted result, stall at random, one long hold-off
	initial begin : sink
		int stall;
		int gap;
		bit held;
		stall = 0;
		held  = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_result(factor, last, invalid);
				results_seen++;
			end
			if (!held && results_seen >= 60) begin
				held  = 1'b1;
				stall = 400;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ready <= 1'b0;
					stall = gap - 1;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// reset, directed then random requests, drain and verdict
	initial begin : source
		int unsigned directed[$];
		int          wait_cycles;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		value    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, one, small primes and squares, longest run, all ones (a large prime)
		directed = {0, 1, 2, 3, 4, 6, 9, 15, 25, 49, 97, 63001, 65521, 131042,
			1073741824, 1610612736, 111546435, 1073741823, 1431655765,
			715827882, 2147483646, 2147483647, 1, 0};
		foreach (directed[i])
			send_value(W'(directed[i]));

		// random part, with a run of back-to-back traffic in the middle
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			steady = (n >= 40 && n < 60);
			send_value(random_value());
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain, then allow for the output register
		while (sb.pending_factors.size() != 0)
			@(posedge clk);
		wait_cycles = 64;
		repeat (wait_cycles) @(posedge clk);
		if (sb.pending_factors.size() != 0)
			sb.report_mismatch("expected results left over");

		if (sb.mismatch_count == 0)
			$display("prime_factorizer_trial_division_top test passed");
		else
			$display("prime_factorizer_trial_division_top test failed");
		$finish;
	end

endmodule
